// ===== rtl/core/yuyv_to_rgb_motion_detect_top_assert.svh =====
// ----------------------------------------------------------------------------
// YUYV to RGB motion detect assertion macros
// Shared assertion forms for the checker of the top level.
// ----------------------------------------------------------------------------
`ifndef YUYV_TO_RGB_MOTION_DETECT_TOP_ASSERT_SVH
`define YUYV_TO_RGB_MOTION_DETECT_TOP_ASSERT_SVH

// Property checked while reset is low.
`define YRMD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define YRMD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/yrmd_pkg.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB motion detect package
// Beat types, register indexes, coefficients and the output clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package yrmd_pkg;

   localparam int MAX_PIXEL_PAIRS = 262144;
   localparam int ADDR_W          = $clog2(MAX_PIXEL_PAIRS);
   localparam int FILL_W          = $clog2(MAX_PIXEL_PAIRS + 1);

   localparam int SUM_W = 27;

   localparam logic signed [17:0] COEF_RV = 18'sd91881;
   localparam logic signed [17:0] COEF_GU = 18'sd22554;
   localparam logic signed [17:0] COEF_GV = 18'sd46802;
   localparam logic signed [17:0] COEF_BU = 18'sd116130;

   localparam logic signed [SUM_W-1:0] CLAMP_TOP = 27'sd16711680;

   localparam logic [7:0]  LUMA_THR_RESET  = 8'd100;
   localparam logic [20:0] COUNT_THR_RESET = 21'h1FFFFF;

   typedef enum logic [0:0] {
      CSR_LUMA_THRESHOLD  = 1'b0,
      CSR_COUNT_THRESHOLD = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_blue;
      logic [7:0] luma_second;
      logic [7:0] chroma_red;
      logic       frame_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  red_first;
      logic [7:0]  green_first;
      logic [7:0]  blue_first;
      logic [7:0]  red_second;
      logic [7:0]  green_second;
      logic [7:0]  blue_second;
      logic        frame_end;
      logic [19:0] changed_count;
      logic        frame_passed;
   } rsp_type;

   function automatic logic [7:0] clamp_q16(input logic signed [SUM_W-1:0] sum);
      logic [7:0] res;
      if (sum < 0) begin
         res = 8'd0;
      end else if (sum >= CLAMP_TOP) begin
         res = 8'd255;
      end else begin
         res = sum[23:16];
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/yuyv_to_rgb_motion_detect_top.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB motion detect top level
// Converts YUYV macropixels to RGB888 pairs and counts lumas that changed
// against the same position of the previous frame.
// ----------------------------------------------------------------------------
//   Channel | Ports                               | Beat
//   --------+-------------------------------------+-----------------------
//   request | req_valid, req_stall, req_data      | one YUYV macropixel
//   result  | rsp_valid, rsp_stall, rsp_data      | two RGB888 pixels
//   config  | csr_write, csr_index, csr_wdata     | one register write
//
// One beat per cycle is taken unless a stalled result holds it back; a result
// passes stage one and then the result register. The luma store is read at
// accept and written back as the beat leaves stage one; a read that meets the
// write of the same entry takes the forwarded data. After reset the store
// needs no clearing pass: a fill mark makes entries never written read as
// zero. A stalled result holds back requests only once stage one is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yuyv_to_rgb_motion_detect_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  yrmd_pkg::req_type      req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output yrmd_pkg::rsp_type      rsp_data,
   input  logic                   csr_write,
   input  yrmd_pkg::csr_index_type csr_index,
   input  logic [20:0]            csr_wdata
);
   import yrmd_pkg::*;

   logic [15:0]       luma_mem [MAX_PIXEL_PAIRS];

   logic [7:0]        luma_thr_ff;
   logic [20:0]       count_thr_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [19:0]       count_ff;
   logic [19:0]       count_in;

   logic              s1_valid_ff;
   req_type           s1_req_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [15:0]       rd_data_ff;
   logic              prev_ok_ff;
   logic              fwd_ff;
   logic [15:0]       fwd_data_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic              advance;
   logic              s1_fire;
   logic              req_fire;
   logic [15:0]       wr_data;
   logic [15:0]       prev;
   logic [7:0]        diff_first;
   logic [7:0]        diff_second;
   logic [1:0]        hits;
   logic [20:0]       count_sum;
   logic [19:0]       count_sat;
   logic [7:0]        first_red;
   logic [7:0]        first_green;
   logic [7:0]        first_blue;
   logic [7:0]        second_red;
   logic [7:0]        second_green;
   logic [7:0]        second_blue;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_fire  = req_valid && !req_stall;

   assign wr_data = {s1_req_ff.luma_second, s1_req_ff.luma_first};
   assign prev    = fwd_ff ? fwd_data_ff : (prev_ok_ff ? rd_data_ff : 16'h0000);

   assign diff_first  = (s1_req_ff.luma_first > prev[7:0]) ?
                        s1_req_ff.luma_first - prev[7:0] :
                        prev[7:0] - s1_req_ff.luma_first;
   assign diff_second = (s1_req_ff.luma_second > prev[15:8]) ?
                        s1_req_ff.luma_second - prev[15:8] :
                        prev[15:8] - s1_req_ff.luma_second;

   assign hits      = {1'b0, diff_first > luma_thr_ff} + {1'b0, diff_second > luma_thr_ff};
   assign count_sum = {1'b0, count_ff} + {19'd0, hits};
   assign count_sat = count_sum[20] ? 20'hFFFFF : count_sum[19:0];

   yrmd_rgb u_rgb_first (
      .luma        (s1_req_ff.luma_first),
      .chroma_blue (s1_req_ff.chroma_blue),
      .chroma_red  (s1_req_ff.chroma_red),
      .red         (first_red),
      .green       (first_green),
      .blue        (first_blue)
   );

   yrmd_rgb u_rgb_second (
      .luma        (s1_req_ff.luma_second),
      .chroma_blue (s1_req_ff.chroma_blue),
      .chroma_red  (s1_req_ff.chroma_red),
      .red         (second_red),
      .green       (second_green),
      .blue        (second_blue)
   );

   always_comb begin
      rsp_data_in.red_first     = first_red;
      rsp_data_in.green_first   = first_green;
      rsp_data_in.blue_first    = first_blue;
      rsp_data_in.red_second    = second_red;
      rsp_data_in.green_second  = second_green;
      rsp_data_in.blue_second   = second_blue;
      rsp_data_in.frame_end     = s1_req_ff.frame_last;
      rsp_data_in.changed_count = s1_req_ff.frame_last ? count_sat : 20'd0;
      rsp_data_in.frame_passed  = s1_req_ff.frame_last &&
                                  ($signed({1'b0, count_sat}) > $signed(count_thr_ff));
   end

   always_comb begin
      addr_in = addr_ff;
      if (req_fire) begin
         if (req_data.frame_last || addr_ff == ADDR_W'(MAX_PIXEL_PAIRS - 1)) begin
            addr_in = '0;
         end else begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      if (s1_fire) begin
         if ({1'b0, s1_addr_ff} == fill_ff) begin
            fill_in = fill_ff + 1'b1;
         end
         count_in = s1_req_ff.frame_last ? 20'd0 : count_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         luma_mem[s1_addr_ff] <= wr_data;
      end
      if (req_fire) begin
         rd_data_ff <= luma_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         luma_thr_ff  <= LUMA_THR_RESET;
         count_thr_ff <= COUNT_THR_RESET;
         addr_ff      <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_LUMA_THRESHOLD: begin
                  luma_thr_ff <= csr_wdata[7:0];
               end
               CSR_COUNT_THRESHOLD: begin
                  count_thr_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         addr_ff  <= addr_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_data;
         s1_addr_ff  <= addr_ff;
         prev_ok_ff  <= {1'b0, addr_ff} < fill_ff;
         fwd_ff      <= s1_fire && (s1_addr_ff == addr_ff);
         fwd_data_ff <= wr_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/yrmd_rgb.sv =====
// ----------------------------------------------------------------------------
// YRMD color converter
// Full-range BT.601 conversion of one luma and a chroma pair to RGB888.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yrmd_rgb (
   input  logic [7:0] luma,
   input  logic [7:0] chroma_blue,
   input  logic [7:0] chroma_red,
   output logic [7:0] red,
   output logic [7:0] green,
   output logic [7:0] blue
);
   import yrmd_pkg::*;

   logic signed [8:0]       u;
   logic signed [8:0]       v;
   logic signed [SUM_W-1:0] base;
   logic signed [SUM_W-1:0] red_sum;
   logic signed [SUM_W-1:0] green_sum;
   logic signed [SUM_W-1:0] blue_sum;

   assign u    = $signed({1'b0, chroma_blue}) - 9'sd128;
   assign v    = $signed({1'b0, chroma_red}) - 9'sd128;
   assign base = $signed({3'b000, luma, 16'h0000});

   assign red_sum   = base + COEF_RV * v;
   assign green_sum = base - COEF_GU * u - COEF_GV * v;
   assign blue_sum  = base + COEF_BU * u;

   assign red   = clamp_q16(red_sum);
   assign green = clamp_q16(green_sum);
   assign blue  = clamp_q16(blue_sum);

endmodule

// ===== rtl/core/yrmd_checker.sv =====
// ----------------------------------------------------------------------------
// YRMD port checker
// Watches the ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "yuyv_to_rgb_motion_detect_top_assert.svh"

module yrmd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input yrmd_pkg::rsp_type rsp_data
);
   import yrmd_pkg::*;

   `YRMD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result beat changed")
   `YRMD_ASSERT(a_mid_frame_zero, clock, reset, rsp_valid && !rsp_data.frame_end |-> rsp_data.changed_count == 20'd0 && !rsp_data.frame_passed, "frame fields set before frame end")
   `YRMD_ASSERT(a_stall_cause, clock, reset, req_stall |-> rsp_valid && rsp_stall, "request stalled while result side is free")
   `YRMD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid right after reset")

endmodule

bind yuyv_to_rgb_motion_detect_top yrmd_checker u_yrmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_yuyv_to_rgb_motion_detect_top.sv =====
// ----------------------------------------------------------------------------
// YUYV to RGB motion detect testbench
// Drives YUYV macropixels and register writes into the top level and checks
// every result beat against a predictor. The predictor keeps its own luma
// history, pair address and change counter. Directed frames cover the color
// extremes and the threshold corners. Random frames follow under changing
// settings with random idle cycles on both channels. A long receiver hold-off
// fills the pipeline. One long frame in which every pixel changes runs back
// to back, and a short frame follows it at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_yuyv_to_rgb_motion_detect_top;

   import yrmd_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 200_000;
   localparam int unsigned RANDOM_ITEMS = 1500;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned LONG_PAIRS   = 160;

   localparam longint COEF_R_V = 91881;
   localparam longint COEF_G_U = 22554;
   localparam longint COEF_G_V = 46802;
   localparam longint COEF_B_U = 116130;
   localparam longint Q16_TOP  = 255 * 65536;

   localparam logic [19:0] COUNT_CEIL = 20'hFFFFF;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_data;
   logic          csr_write = 1'b0;
   csr_index_type csr_index = CSR_LUMA_THRESHOLD;
   logic [20:0]   csr_wdata = '0;

   logic [7:0]         luma_limit;
   logic signed [20:0] count_limit;
   logic [15:0]        luma_history [0:MAX_PIXEL_PAIRS-1];
   logic [ADDR_W-1:0]  history_addr;
   logic [19:0]        changed_pixels;

   rsp_type     expected_pixels [$];
   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   int unsigned random_sent  = 0;
   int unsigned hold_off_len = 0;
   int unsigned stall_left   = 0;
   bit          req_idle_on  = 1'b0;
   bit          rsp_idle_on  = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   yuyv_to_rgb_motion_detect_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic logic [7:0] saturate_q16(input longint acc);
      logic [7:0] res;
      if (acc < 0) begin
         res = 8'd0;
      end else if (acc >= Q16_TOP) begin
         res = 8'd255;
      end else begin
         res = 8'(acc >> 16);
      end
      return res;
   endfunction

   function automatic logic [23:0] yuv_to_rgb(input logic [7:0] y, input logic [7:0] cb,
                                              input logic [7:0] cr);
      longint base;
      longint u;
      longint v;
      base = longint'(y) * 65536;
      u    = longint'(cb) - 128;
      v    = longint'(cr) - 128;
      return {saturate_q16(base + COEF_R_V * v),
              saturate_q16(base - COEF_G_U * u - COEF_G_V * v),
              saturate_q16(base + COEF_B_U * u)};
   endfunction

   function automatic bit luma_moved(input logic [7:0] now_y, input logic [7:0] old_y);
      logic [7:0] diff;
      diff = (now_y > old_y) ? now_y - old_y : old_y - now_y;
      return diff > luma_limit;
   endfunction

   function automatic rsp_type convert_and_count(input req_type px);
      rsp_type     res;
      logic [15:0] old;
      logic [20:0] total;
      old = luma_history[history_addr];
      {res.red_first, res.green_first, res.blue_first} =
         yuv_to_rgb(px.luma_first, px.chroma_blue, px.chroma_red);
      {res.red_second, res.green_second, res.blue_second} =
         yuv_to_rgb(px.luma_second, px.chroma_blue, px.chroma_red);
      total = {1'b0, changed_pixels} + 21'(luma_moved(px.luma_first, old[7:0]))
              + 21'(luma_moved(px.luma_second, old[15:8]));
      luma_history[history_addr] = {px.luma_second, px.luma_first};
      changed_pixels = (total > {1'b0, COUNT_CEIL}) ? COUNT_CEIL : total[19:0];
      res.frame_end = px.frame_last;
      if (px.frame_last) begin
         res.changed_count = changed_pixels;
         res.frame_passed  = $signed({1'b0, changed_pixels}) > count_limit;
         changed_pixels    = '0;
         history_addr      = '0;
      end else begin
         res.changed_count = '0;
         res.frame_passed  = 1'b0;
         history_addr      = history_addr + 1'b1;
      end
      return res;
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      int unsigned len;
      r = $urandom_range(0, 99);
      if (r < 65) begin
         len = 0;
      end else if (r < 95) begin
         len = $urandom_range(1, 3);
      end else begin
         len = $urandom_range(4, 40);
      end
      return len;
   endfunction

   function automatic logic [7:0] pick_chroma();
      logic [7:0] c;
      case ($urandom_range(0, 7))
         0: begin
            c = 8'd0;
         end
         1: begin
            c = 8'd255;
         end
         default: begin
            c = 8'($urandom);
         end
      endcase
      return c;
   endfunction

   function automatic logic [7:0] nudge_luma(input logic [7:0] old);
      int t;
      int unsigned delta;
      delta = $urandom_range(0, int'(luma_limit) + 3);
      t = $urandom_range(0, 1) ? int'(old) + int'(delta) : int'(old) - int'(delta);
      if (t < 0) begin
         t = 0;
      end else if (t > 255) begin
         t = 255;
      end
      return 8'(t);
   endfunction

   function automatic req_type make_macropixel(input logic [7:0] y0, input logic [7:0] cb,
                                               input logic [7:0] y1, input logic [7:0] cr,
                                               input logic last);
      req_type px;
      px.luma_first  = y0;
      px.chroma_blue = cb;
      px.luma_second = y1;
      px.chroma_red  = cr;
      px.frame_last  = last;
      return px;
   endfunction

   task automatic compare_field(input string name, input logic [19:0] want,
                                input logic [19:0] got);
      if (got !== want) begin
         if (mismatches < REPORT_LIMIT) begin
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
         end
         mismatches++;
      end
   endtask

   task automatic check_pixel_pair(input rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         if (mismatches < REPORT_LIMIT) begin
            $display("result beat with nothing expected: %h", got);
         end
         mismatches++;
      end else begin
         want = expected_pixels.pop_front();
         compare_field("red_first", want.red_first, got.red_first);
         compare_field("green_first", want.green_first, got.green_first);
         compare_field("blue_first", want.blue_first, got.blue_first);
         compare_field("red_second", want.red_second, got.red_second);
         compare_field("green_second", want.green_second, got.green_second);
         compare_field("blue_second", want.blue_second, got.blue_second);
         compare_field("frame_end", want.frame_end, got.frame_end);
         compare_field("changed_count", want.changed_count, got.changed_count);
         compare_field("frame_passed", want.frame_passed, got.frame_passed);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_pixel_pair(rsp_data);
         end
         if (hold_off_len != 0) begin
            stall_left   = hold_off_len;
            hold_off_len = 0;
         end else if (stall_left == 0 && rsp_idle_on) begin
            stall_left = idle_length();
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_macropixel(input req_type px);
      int unsigned gap;
      gap = req_idle_on ? idle_length() : 0;
      expected_pixels.push_back(convert_and_count(px));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [20:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_LUMA_THRESHOLD: begin
            luma_limit = value[7:0];
         end
         CSR_COUNT_THRESHOLD: begin
            count_limit = value;
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_frame(input int unsigned pairs, input bit nearby);
      req_type     px;
      logic [15:0] old;
      for (int unsigned k = 0; k < pairs; k++) begin
         old            = luma_history[history_addr];
         px.chroma_blue = pick_chroma();
         px.chroma_red  = pick_chroma();
         if (nearby) begin
            px.luma_first  = nudge_luma(old[7:0]);
            px.luma_second = nudge_luma(old[15:8]);
         end else begin
            px.luma_first  = 8'($urandom);
            px.luma_second = 8'($urandom);
         end
         px.frame_last = (k == pairs - 1);
         send_macropixel(px);
         random_sent++;
      end
   endtask

   task automatic test_color_extremes();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_macropixel(make_macropixel(8'd0, 8'd128, 8'd255, 8'd128, 1'b0));
      send_macropixel(make_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
      send_macropixel(make_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b0));
      send_macropixel(make_macropixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b0));
      send_macropixel(make_macropixel(8'd128, 8'd0, 8'd128, 8'd255, 1'b0));
      send_macropixel(make_macropixel(8'd16, 8'd240, 8'd235, 8'd16, 1'b0));
      send_macropixel(make_macropixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0));
      send_macropixel(make_macropixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1));
      wait_for_results();
   endtask

   task automatic test_change_thresholds();
      // Upper data bits of the luma write must be dropped by the block.
      write_register(CSR_LUMA_THRESHOLD, 21'h1FFF00);
      write_register(CSR_COUNT_THRESHOLD, 21'd1);
      send_macropixel(make_macropixel(8'd0, 8'd100, 8'd254, 8'd150, 1'b0));
      send_macropixel(make_macropixel(8'd255, 8'd128, 8'd0, 8'd128, 1'b0));
      send_macropixel(make_macropixel(8'd1, 8'd60, 8'd255, 8'd200, 1'b1));
      wait_for_results();
      write_register(CSR_LUMA_THRESHOLD, 21'd255);
      write_register(CSR_COUNT_THRESHOLD, 21'd0);
      send_macropixel(make_macropixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0));
      send_macropixel(make_macropixel(8'd0, 8'd255, 8'd255, 8'd0, 1'b1));
      wait_for_results();
      write_register(CSR_LUMA_THRESHOLD, 21'd200);
      write_register(CSR_COUNT_THRESHOLD, 21'd524288);
      send_macropixel(make_macropixel(8'd0, 8'd128, 8'd0, 8'd128, 1'b1));
      send_macropixel(make_macropixel(8'd255, 8'd30, 8'd0, 8'd220, 1'b0));
      send_macropixel(make_macropixel(8'd40, 8'd128, 8'd250, 8'd128, 1'b1));
      wait_for_results();
   endtask

   task automatic test_random_frames();
      int unsigned frames;
      int unsigned pairs;
      logic [7:0]  luma_pick;
      logic [20:0] count_pick;
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: begin
               luma_pick = 8'd0;
            end
            1: begin
               luma_pick = 8'd255;
            end
            default: begin
               luma_pick = 8'($urandom_range(0, 255));
            end
         endcase
         case ($urandom_range(0, 5))
            0: begin
               count_pick = 21'h1FFFFF;
            end
            1: begin
               count_pick = 21'd0;
            end
            2: begin
               count_pick = 21'd524288;
            end
            3: begin
               count_pick = 21'($urandom_range(0, 524288));
            end
            default: begin
               count_pick = 21'($urandom_range(0, 60));
            end
         endcase
         write_register(CSR_LUMA_THRESHOLD, {13'($urandom), luma_pick});
         write_register(CSR_COUNT_THRESHOLD, count_pick);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         frames = $urandom_range(2, 6);
         repeat (frames) begin
            pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150)
                                                : $urandom_range(1, 24);
            send_frame(pairs, 1'($urandom_range(0, 1)));
         end
         wait_for_results();
      end
   endtask

   task automatic test_backpressure();
      req_idle_on  = 1'b0;
      rsp_idle_on  = 1'b0;
      hold_off_len = HOLD_CYCLES;
      send_frame(40, 1'b0);
      wait_for_results();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_frame(12, 1'b1);
      wait_for_results();
      send_frame(12, 1'b1);
      wait_for_results();
   endtask

   task automatic test_long_frame();
      req_type     px;
      logic [15:0] old;
      // Every luma moves by at least 128 against the entry it meets, so each
      // pixel counts.
      write_register(CSR_LUMA_THRESHOLD, 21'd127);
      write_register(CSR_COUNT_THRESHOLD, 21'd300);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      for (int unsigned k = 0; k < LONG_PAIRS; k++) begin
         old            = luma_history[history_addr];
         px.luma_first  = (old[7:0] < 8'd128) ? 8'd255 : 8'd0;
         px.luma_second = (old[15:8] < 8'd128) ? 8'd255 : 8'd0;
         px.chroma_blue = 8'($urandom);
         px.chroma_red  = 8'($urandom);
         px.frame_last  = (k == LONG_PAIRS - 1);
         send_macropixel(px);
      end
      wait_for_results();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      send_frame(6, 1'b1);
      wait_for_results();
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      luma_limit     = 8'd100;
      count_limit    = -21'sd1;
      history_addr   = '0;
      changed_pixels = '0;
      for (int i = 0; i < MAX_PIXEL_PAIRS; i++) begin
         luma_history[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_color_extremes();
      test_change_thresholds();
      test_random_frames();
      test_backpressure();
      test_long_frame();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_pixels.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
